// File: rtl/core/xbs_pkg.sv
`default_nettype none
package xbs_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int BLK_AW      = $clog2(BLOCK_BYTES);
    localparam int LENGTH_BITS = 24;

    // send positions within one block frame: SOH, number, complement, data, sum
    localparam logic [7:0] POS_SOH   = 8'd0;
    localparam logic [7:0] POS_NUM   = 8'd1;
    localparam logic [7:0] POS_CPL   = 8'd2;
    localparam logic [7:0] POS_DATA  = 8'd3;
    localparam logic [7:0] POS_SUM   = 8'(3 + BLOCK_BYTES);

    localparam logic [7:0] FILL_FULL = 8'(BLOCK_BYTES);

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam logic [7:0] RETRY_RESET = 8'd10;

    // request kinds on s_tuser
    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_BYTE  = 3'd1;
    localparam logic [2:0] REQ_REPLY = 3'd2;
    localparam logic [2:0] REQ_TMO   = 3'd3;
    localparam logic [2:0] REQ_PULL  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_PAD_BYTE    = 2'd1;

    // reported phase codes
    localparam logic [2:0] PC_IDLE  = 3'd0;
    localparam logic [2:0] PC_POLL  = 3'd1;
    localparam logic [2:0] PC_FILL  = 3'd2;
    localparam logic [2:0] PC_SEND  = 3'd3;
    localparam logic [2:0] PC_ACK   = 3'd4;
    localparam logic [2:0] PC_EOT   = 3'd5;
    localparam logic [2:0] PC_DONE  = 3'd6;
    localparam logic [2:0] PC_ABORT = 3'd7;

    // result word layout on m_tdata
    localparam int OF_TXV   = 0;
    localparam int OF_TXB   = 1;
    localparam int OF_PHASE = 9;
    localparam int OF_BLK   = 12;
    localparam int OF_RETRY = 20;
    localparam int OF_WANT  = 28;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_POLL  = 8'b0000_0010,
        PH_FILL  = 8'b0000_0100,
        PH_SEND  = 8'b0000_1000,
        PH_ACK   = 8'b0001_0000,
        PH_EOT   = 8'b0010_0000,
        PH_DONE  = 8'b0100_0000,
        PH_ABORT = 8'b1000_0000
    } phase_t;

    function automatic logic [2:0] phase_code(phase_t ph);
        logic [2:0] c;
        case (ph)
            PH_IDLE:  c = PC_IDLE;
            PH_POLL:  c = PC_POLL;
            PH_FILL:  c = PC_FILL;
            PH_SEND:  c = PC_SEND;
            PH_ACK:   c = PC_ACK;
            PH_EOT:   c = PC_EOT;
            PH_DONE:  c = PC_DONE;
            PH_ABORT: c = PC_ABORT;
            default:  c = PC_IDLE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/xmodem_block_sender.sv
`default_nettype none
// XMODEM sender, 8-bit checksum variant.
// Input channel (s_*): one request per transfer. s_tuser carries the request
//   kind (start, file byte, reply byte, reply timeout, transmitter pull);
//   s_tdata carries the data byte and, on start, the file length.
// Result channel (m_*): exactly one result per request: tx_valid/tx_byte for
//   the serial transmitter, plus phase, block number, retries left and a flag
//   telling the host whether another file byte would be taken.
// Config channel (cfg_*): retry limit (index 0) and pad byte (index 1); always
//   ready, meant to be written while the block is idle.
// Latency: the result appears on m_* the cycle after its request transfer.
// Throughput: one request per cycle while the result channel is not stalled. Block data sits in a 128x8
//   RAM with registered read; the read address is driven from the
//   next send position every cycle so the data byte for a pull is waiting.
// Stalls: the result register holds while m_tready is low and s_tready drops
//   only when that register is full and not being drained.
// Reset (aresetn low, synchronous): phase idle, block number 1, counters
//   zero, retry limit 10, pad byte 0. The buffer RAM is not cleared; only
//   bytes written for the current block are ever sent.
module xmodem_block_sender (
    input  wire         aclk,
    input  wire         aresetn,
    // input requests
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [7:0] data_byte, [31:8] file_length
    input  wire  [2:0]  s_tuser,   // [2:0] req_type
    // results
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [0] tx_valid, [8:1] tx_byte, [11:9] phase,
                                   // [19:12] blk_seq, [27:20] retries_left,
                                   // [28] want_data, [31:29] zero
    // configuration
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);

    localparam int LB = xbs_pkg::LENGTH_BITS;

    // control state
    xbs_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]       fill_reg, fill_next;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       seq_reg, seq_next;
    logic [LB-1:0]    remain_reg, remain_next;
    logic [7:0]       retry_reg, retry_next;
    logic [7:0]       limit_reg;
    logic [7:0]       pad_reg;
    logic             out_valid_reg;
    logic [31:0]      out_data_reg;

    logic             in_xfer;
    logic [7:0]       data_byte;
    logic [LB-1:0]    file_length;
    logic [2:0]       req;

    logic             txv;
    logic [7:0]       txb;
    logic             want;
    logic [7:0]       k_idx;
    logic [7:0]       rd_full;

    logic                         ram_we;
    logic [xbs_pkg::BLK_AW-1:0]   ram_wa;
    logic [xbs_pkg::BLK_AW-1:0]   ram_ra;
    logic [7:0]                   ram_rd;

    assign data_byte   = s_tdata[7:0];
    assign file_length = s_tdata[8 +: LB];
    assign req         = s_tuser;

    // output register: take a new item when empty or being drained
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign k_idx = pos_reg - xbs_pkg::POS_DATA;

    always_comb begin
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        seq_next    = seq_reg;
        remain_next = remain_reg;
        retry_next  = retry_reg;
        txv         = 1'b0;
        txb         = 8'h00;
        ram_we      = 1'b0;
        ram_wa      = fill_reg[xbs_pkg::BLK_AW-1:0];

        if (in_xfer) begin
            case (req)
                xbs_pkg::REQ_START: begin
                    remain_next = file_length;
                    seq_next    = 8'd1;
                    retry_next  = limit_reg;
                    fill_next   = 8'd0;
                    pos_next    = 8'd0;
                    sum_next    = 8'd0;
                    phase_next  = xbs_pkg::PH_POLL;
                end
                xbs_pkg::REQ_BYTE: begin
                    if (phase_reg == xbs_pkg::PH_FILL && fill_reg < xbs_pkg::FILL_FULL
                        && remain_reg != '0) begin
                        ram_we      = 1'b1;
                        fill_next   = fill_reg + 8'd1;
                        remain_next = remain_reg - LB'(1);
                        if (fill_next >= xbs_pkg::FILL_FULL || remain_next == '0) begin
                            phase_next = xbs_pkg::PH_SEND;
                            pos_next   = 8'd0;
                        end
                    end
                end
                xbs_pkg::REQ_REPLY, xbs_pkg::REQ_TMO: begin
                    if (phase_reg == xbs_pkg::PH_POLL || phase_reg == xbs_pkg::PH_ACK) begin
                        if (req == xbs_pkg::REQ_REPLY &&
                            ((phase_reg == xbs_pkg::PH_POLL && data_byte == xbs_pkg::CH_NAK) ||
                             (phase_reg == xbs_pkg::PH_ACK  && data_byte == xbs_pkg::CH_ACK))) begin
                            if (phase_reg == xbs_pkg::PH_ACK) begin
                                seq_next = (seq_reg == 8'hFF) ? 8'd1 : seq_reg + 8'd1;
                            end
                            // next block, or EOT once the file is exhausted
                            if (remain_reg == '0) begin
                                phase_next = xbs_pkg::PH_EOT;
                            end else begin
                                phase_next = xbs_pkg::PH_FILL;
                                fill_next  = 8'd0;
                                retry_next = limit_reg;
                            end
                        end else if (retry_reg <= 8'd1) begin
                            retry_next = 8'd0;
                            phase_next = xbs_pkg::PH_ABORT;
                        end else begin
                            retry_next = retry_reg - 8'd1;
                            if (phase_reg == xbs_pkg::PH_ACK) begin
                                phase_next = xbs_pkg::PH_SEND;
                                pos_next   = 8'd0;
                            end
                        end
                    end
                end
                xbs_pkg::REQ_PULL: begin
                    if (phase_reg == xbs_pkg::PH_SEND) begin
                        txv = 1'b1;
                        if (pos_reg == xbs_pkg::POS_SOH) begin
                            txb      = xbs_pkg::CH_SOH;
                            sum_next = 8'd0;
                        end else if (pos_reg == xbs_pkg::POS_NUM) begin
                            txb = seq_reg;
                        end else if (pos_reg == xbs_pkg::POS_CPL) begin
                            txb = ~seq_reg;
                        end else if (pos_reg < xbs_pkg::POS_SUM) begin
                            txb      = (k_idx < fill_reg) ? ram_rd : pad_reg;
                            sum_next = sum_reg + txb;
                        end else begin
                            txb = sum_reg;
                        end
                        if (pos_reg >= xbs_pkg::POS_SUM) begin
                            pos_next   = 8'd0;
                            phase_next = xbs_pkg::PH_ACK;
                        end else begin
                            pos_next = pos_reg + 8'd1;
                        end
                    end else if (phase_reg == xbs_pkg::PH_EOT) begin
                        txv        = 1'b1;
                        txb        = xbs_pkg::CH_EOT;
                        phase_next = xbs_pkg::PH_DONE;
                    end
                end
                default: begin
                    // unknown request kinds are ignored
                end
            endcase
        end

        want = (phase_next == xbs_pkg::PH_FILL) && (fill_next < xbs_pkg::FILL_FULL)
               && (remain_next != '0);
    end

    // prefetch the data byte for the position that the next pull will use
    assign rd_full = pos_next - xbs_pkg::POS_DATA;
    assign ram_ra  = rd_full[xbs_pkg::BLK_AW-1:0];

    xbs_ram #(
        .WIDTH (8),
        .DEPTH (xbs_pkg::BLOCK_BYTES)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (data_byte),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= xbs_pkg::PH_IDLE;
            fill_reg      <= 8'd0;
            pos_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            seq_reg       <= 8'd1;
            remain_reg    <= '0;
            retry_reg     <= 8'd0;
            limit_reg     <= xbs_pkg::RETRY_RESET;
            pad_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            seq_reg    <= seq_next;
            remain_reg <= remain_next;
            retry_reg  <= retry_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == xbs_pkg::CFG_RETRY_LIMIT) begin
                    limit_reg <= cfg_data;
                end else if (cfg_index == xbs_pkg::CFG_PAD_BYTE) begin
                    pad_reg <= cfg_data;
                end
            end
            if (in_xfer) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_data_reg <= {3'b000, want, retry_next, seq_next,
                             xbs_pkg::phase_code(phase_next), txb, txv};
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/xbs_ram.sv
`default_nettype none
module xbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire [WIDTH-1:0]           wr_data,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/core/xbs_checker.sv
`default_nettype none
module xbs_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata
);

    logic       txv;
    logic [7:0] txb;
    logic [2:0] ph;
    logic       want;

    assign txv  = m_tdata[xbs_pkg::OF_TXV];
    assign txb  = m_tdata[xbs_pkg::OF_TXB +: 8];
    assign ph   = m_tdata[xbs_pkg::OF_PHASE +: 3];
    assign want = m_tdata[xbs_pkg::OF_WANT];

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_quiet_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !txv |-> txb == 8'h00)
        else $error("tx_byte nonzero without tx_valid");

    a_want_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && want |-> ph == xbs_pkg::PC_FILL)
        else $error("want_data outside filling");

    a_tx_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && txv |-> (ph == xbs_pkg::PC_SEND || ph == xbs_pkg::PC_ACK ||
                             ph == xbs_pkg::PC_DONE))
        else $error("byte transmitted in wrong phase");

endmodule

bind xmodem_block_sender xbs_checker u_xbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// File: test/tb_xmodem_block_sender.sv
`timescale 1ns / 100ps

module tb_xmodem_block_sender;

    import xbs_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
    localparam int          RX_HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int          SETTLE_CYCLES  = 4;      // registered result plus margin
    localparam int          FRAME_PULLS    = int'(POS_SUM) + 1;
    localparam int          MAX_PRINTS     = 100;
    localparam int          PHASE_ITEMS    = 30;
    localparam logic [2:0]  REQ_JUNK_HI    = 3'd7;   // kinds above REQ_PULL mean nothing
    localparam logic [1:0]  CFG_SPARE      = 2'd2;   // first unused register index
    localparam logic [7:0]  LIMIT_MAX      = 8'd255;

    // one result, laid out like m_tdata[28:0]
    typedef struct packed {
        logic       want;
        logic [7:0] retries;
        logic [7:0] blk;
        logic [2:0] phase;
        logic [7:0] txb;
        logic       txv;
    } sender_out_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    xmodem_block_sender i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Predictor state, at reset values
    // ---------------------------------------------------------------------
    logic [7:0]  blk_mem [BLOCK_BYTES];
    logic [7:0]  lim_reg    = RETRY_RESET;
    logic [7:0]  pad_reg    = 8'h00;
    logic [7:0]  fill_cnt   = 8'd0;
    logic [7:0]  send_pos   = POS_SOH;
    logic [7:0]  csum       = 8'd0;
    logic [7:0]  seq_no     = 8'd1;
    logic [23:0] bytes_left = 24'd0;
    logic [7:0]  retry_cnt  = 8'd0;
    logic [2:0]  ph         = PC_IDLE;

    sender_out_t due_results[$];
    sender_out_t oldest;

    int unsigned err_count    = 0;
    int unsigned item_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned src_idle_pct = 15;
    int unsigned rx_stall_pct = 15;
    int unsigned rx_hold_cnt  = 0;
    bit          rx_hold_req  = 1'b0;
    logic [7:0]  cfg_limit    = RETRY_RESET;   // stimulus-side copy, for planning

    function automatic bit taking_bytes();
        return ph == PC_FILL && fill_cnt < FILL_FULL && bytes_left != '0;
    endfunction

    function automatic void open_block();
        if (bytes_left == '0) begin
            ph = PC_EOT;
        end else begin
            ph        = PC_FILL;
            fill_cnt  = '0;
            retry_cnt = lim_reg;
        end
    endfunction

    // returns 1 when the retries are used up (aborts)
    function automatic bit count_failure();
        if (retry_cnt <= 8'd1) begin
            retry_cnt = '0;
            ph        = PC_ABORT;
            return 1'b1;
        end
        retry_cnt--;
        return 1'b0;
    endfunction

    // one request in, one result out
    function automatic sender_out_t sender_step(input logic [2:0]  kind,
                                                input logic [7:0]  dbyte,
                                                input logic [23:0] len);
        sender_out_t r;
        logic [7:0]  k;
        r = '0;
        case (kind)
            REQ_START: begin
                bytes_left = len;
                seq_no     = 8'd1;
                retry_cnt  = lim_reg;
                fill_cnt   = '0;
                send_pos   = POS_SOH;
                csum       = '0;
                ph         = PC_POLL;
            end
            REQ_BYTE: begin
                if (taking_bytes()) begin
                    blk_mem[fill_cnt[BLK_AW-1:0]] = dbyte;
                    fill_cnt++;
                    bytes_left--;
                    if (fill_cnt >= FILL_FULL || bytes_left == '0) begin
                        ph       = PC_SEND;
                        send_pos = POS_SOH;
                    end
                end
            end
            REQ_REPLY, REQ_TMO: begin
                if (ph == PC_POLL) begin
                    if (kind == REQ_REPLY && dbyte == CH_NAK)
                        open_block();
                    else
                        void'(count_failure());
                end else if (ph == PC_ACK) begin
                    if (kind == REQ_REPLY && dbyte == CH_ACK) begin
                        seq_no++;
                        if (seq_no == '0)
                            seq_no = 8'd1;
                        open_block();
                    end else if (!count_failure()) begin
                        ph       = PC_SEND;
                        send_pos = POS_SOH;
                    end
                end
            end
            REQ_PULL: begin
                if (ph == PC_SEND) begin
                    r.txv = 1'b1;
                    if (send_pos == POS_SOH) begin
                        r.txb = CH_SOH;
                        csum  = '0;
                    end else if (send_pos == POS_NUM) begin
                        r.txb = seq_no;
                    end else if (send_pos == POS_CPL) begin
                        r.txb = ~seq_no;            // 255 - n
                    end else if (send_pos < POS_SUM) begin
                        k     = send_pos - POS_DATA;
                        r.txb = (k < fill_cnt) ? blk_mem[k[BLK_AW-1:0]] : pad_reg;
                        csum  = csum + r.txb;
                    end else begin
                        r.txb = csum;
                    end
                    if (send_pos >= POS_SUM) begin
                        send_pos = POS_SOH;
                        ph       = PC_ACK;
                    end else begin
                        send_pos++;
                    end
                end else if (ph == PC_EOT) begin
                    r.txv = 1'b1;
                    r.txb = CH_EOT;
                    ph    = PC_DONE;
                end
            end
            default: ;
        endcase
        r.phase   = ph;
        r.blk     = seq_no;
        r.retries = retry_cnt;
        r.want    = taking_bytes();
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Monitor: config and request transfers feed the predictor, result
    // transfers are checked against the oldest prediction. Push comes before
    // pop so a same-edge pair is still handled in order.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RETRY_LIMIT)
                    lim_reg = cfg_data;
                else if (cfg_index == CFG_PAD_BYTE)
                    pad_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                due_results.push_back(sender_step(s_tuser, s_tdata[7:0], s_tdata[31:8]));
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    oldest = due_results.pop_front();
                    if (m_tdata[OF_TXV] !== oldest.txv)
                        report_mismatch("tx_valid", m_tdata[OF_TXV], oldest.txv);
                    if (m_tdata[OF_TXB +: 8] !== oldest.txb)
                        report_mismatch("tx_byte", m_tdata[OF_TXB +: 8], oldest.txb);
                    if (m_tdata[OF_PHASE +: 3] !== oldest.phase)
                        report_mismatch("phase", m_tdata[OF_PHASE +: 3], oldest.phase);
                    if (m_tdata[OF_BLK +: 8] !== oldest.blk)
                        report_mismatch("blk_seq", m_tdata[OF_BLK +: 8], oldest.blk);
                    if (m_tdata[OF_RETRY +: 8] !== oldest.retries)
                        report_mismatch("retries_left", m_tdata[OF_RETRY +: 8], oldest.retries);
                    if (m_tdata[OF_WANT] !== oldest.want)
                        report_mismatch("want_data", m_tdata[OF_WANT], oldest.want);
                    if (m_tdata[31:OF_WANT+1] !== '0)
                        report_mismatch("unused tdata bits", m_tdata[31:OF_WANT+1], '0);
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when asked for one
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_cnt = RX_HOLD_CYCLES;
        end
        if (rx_hold_cnt != 0) begin
            rx_hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_xmodem_block_sender failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Offer one request and hold it until the transfer. Valid stays high
    // into the next call unless a gap is drawn.
    task automatic send_req(input logic [2:0] kind, input logic [7:0] dbyte,
                            input logic [23:0] len, input bit counted);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {len, dbyte};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (counted)
            item_count++;
    endtask

    task automatic send_start(input logic [23:0] len);
        send_req(REQ_START, 8'($urandom), len, 1'b1);
    endtask

    task automatic send_reply(input logic [7:0] rx_byte);
        send_req(REQ_REPLY, rx_byte, 24'($urandom), 1'b1);
    endtask

    task automatic send_kind(input logic [2:0] kind);
        send_req(kind, 8'($urandom), 24'($urandom), 1'b1);
    endtask

    // timeout or a reply byte other than the one hoped for
    task automatic send_failure(input logic [7:0] good);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == good)
            b = ~good;
        if ($urandom_range(1))
            send_kind(REQ_TMO);
        else
            send_reply(b);
    endtask

    // a request the block ignores in fill and send; live_kind is the one that
    // would count in the current phase
    task automatic send_noise(input logic [2:0] live_kind);
        logic [2:0] kind;
        kind = 3'($urandom_range(REQ_BYTE, REQ_JUNK_HI));
        if (kind == live_kind)
            kind = REQ_TMO;
        send_req(kind, 8'($urandom), 24'($urandom), 1'b0);
    endtask

    task automatic fill_bytes(input int unsigned n, input int unsigned noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_noise(REQ_BYTE);
            send_kind(REQ_BYTE);
        end
    endtask

    task automatic pull_frame(input int unsigned noise_pct);
        for (int i = 0; i < FRAME_PULLS; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_noise(REQ_PULL);
            send_kind(REQ_PULL);
        end
    endtask

    // Sender pauses until every result is back, then lets the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_transfer(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // writes both registers plus one unused index, with the block idle
    task automatic set_config(input logic [7:0] limit, input logic [7:0] pad);
        wait_idle();
        cfg_transfer(CFG_RETRY_LIMIT, limit);
        cfg_transfer(CFG_PAD_BYTE, pad);
        cfg_transfer(CFG_SPARE | 2'($urandom_range(1)), 8'($urandom));
        cfg_valid <= 1'b0;
        cfg_limit = limit;
    endtask

    // A complete file transfer as a well-behaved receiver would see it,
    // with random failures; returns early where the block aborts.
    task automatic run_file(input logic [23:0] len, input int unsigned fail_pct,
                            input int unsigned noise_pct);
        int unsigned left;
        int unsigned n;
        int unsigned fails;
        int unsigned cap;
        left = len;
        cap  = (cfg_limit == '0) ? 1 : cfg_limit;
        send_start(len);
        fails = 0;
        while ($urandom_range(99) < fail_pct) begin
            send_failure(CH_NAK);
            fails++;
            if (fails >= cap)
                return;
        end
        send_reply(CH_NAK);
        while (left != 0) begin
            n = (left > BLOCK_BYTES) ? BLOCK_BYTES : left;
            fill_bytes(n, noise_pct);
            left -= n;
            fails = 0;
            forever begin
                pull_frame(noise_pct);
                if ($urandom_range(99) >= fail_pct)
                    break;
                send_failure(CH_ACK);
                fails++;
                if (fails >= cap)
                    return;
            end
            send_reply(CH_ACK);
        end
        send_kind(REQ_PULL);    // EOT
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // every request kind but start, straight out of reset: all ignored
    task automatic test_idle_requests();
        for (int k = REQ_BYTE; k <= REQ_JUNK_HI; k++)
            send_kind(3'(k));
    endtask

    // zero-length file: poll goes straight to EOT; reset register values
    task automatic test_empty_file();
        send_start('0);
        send_kind(REQ_BYTE);
        send_reply(CH_NAK);
        send_kind(REQ_BYTE);
        send_kind(REQ_TMO);
        send_kind(REQ_PULL);
        send_kind(REQ_PULL);
        send_reply(CH_ACK);
    endtask

    // failures while polling and per block, resend from SOH, padding, then
    // an abort while polling
    task automatic test_retries();
        set_config(8'd3, 8'h5A);
        send_start(24'd2);
        send_kind(REQ_TMO);
        send_reply(CH_ACK);
        send_reply(CH_NAK);
        send_req(REQ_BYTE, 8'hFF, 24'($urandom), 1'b1);
        send_req(REQ_BYTE, 8'h00, 24'($urandom), 1'b1);
        pull_frame(0);
        send_reply(CH_NAK);
        pull_frame(0);
        send_kind(REQ_TMO);
        pull_frame(0);
        send_reply(CH_ACK);
        send_kind(REQ_PULL);
        send_start(24'd2);
        send_kind(REQ_TMO);
        send_kind(REQ_TMO);
        send_kind(REQ_TMO);
        send_kind(REQ_PULL);
    endtask

    // limit 0 and 1: the first failure aborts, with no resend
    task automatic test_abort_edges();
        set_config(8'd0, 8'hFF);
        send_start(24'd1);
        send_reply(8'h00);
        set_config(8'd1, 8'hFF);
        send_start(24'd1);
        send_reply(CH_NAK);
        send_kind(REQ_BYTE);
        pull_frame(0);
        send_kind(REQ_TMO);
        send_kind(REQ_PULL);
        send_reply(CH_ACK);
    endtask

    // start while polling, filling, sending, in EOT and in done
    task automatic test_restart();
        set_config(RETRY_RESET, 8'h00);
        send_start(24'hFFFFFF);
        send_reply(CH_NAK);
        fill_bytes(3, 0);
        send_start(24'($urandom));
        send_start(24'($urandom));
        send_reply(CH_NAK);
        fill_bytes(2, 0);
        send_start(24'd1);
        send_reply(CH_NAK);
        send_kind(REQ_BYTE);
        send_kind(REQ_PULL);
        send_kind(REQ_PULL);
        send_start('0);
        send_reply(CH_NAK);
        send_start('0);
        send_reply(CH_NAK);
        send_kind(REQ_PULL);
        send_start(24'd1);
    endtask

    // sender pauses until drained, then the receiver holds off while
    // requests keep coming, so the block has to stall its input
    task automatic test_backpressure();
        src_idle_pct = 0;
        rx_stall_pct = 0;
        set_config(8'd4, 8'h3C);
        send_start(24'd5);
        send_reply(CH_NAK);
        wait_idle();
        rx_hold_req = 1'b1;
        fill_bytes(5, 0);
        pull_frame(0);
        send_reply(CH_ACK);
        send_kind(REQ_PULL);
    endtask

    // random transfers in four idling phases
    task automatic test_random();
        int unsigned goal;
        int unsigned pick;
        logic [23:0] len;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    src_idle_pct = 0;
                    rx_stall_pct = 0;
                    set_config(LIMIT_MAX, 8'h00);
                end
                1: begin
                    src_idle_pct = 69;
                    rx_stall_pct = 0;
                    set_config(8'd1, 8'hFF);
                end
                2: begin
                    src_idle_pct = 0;
                    rx_stall_pct = 69;
                    set_config(8'($urandom_range(2, 6)), 8'($urandom));
                end
                default: begin
                    src_idle_pct = 15;
                    rx_stall_pct = 15;
                    set_config(8'($urandom_range(1, 255)), 8'($urandom));
                end
            endcase
            goal = item_count + PHASE_ITEMS;
            while (item_count < goal) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    // abandoned transfer, cut off by the next start
                    send_start(24'($urandom));
                    send_reply(CH_NAK);
                    fill_bytes($urandom_range(1, 100), 4);
                end else begin
                    if (pick < 11)
                        len = '0;
                    else if (pick < 65)
                        len = 24'($urandom_range(1, 20));
                    else if (pick < 90)
                        len = 24'($urandom_range(21, 140));
                    else
                        len = 24'($urandom_range(141, 300));
                    run_file(len, 12, 4);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_START;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_requests();
        test_empty_file();
        test_retries();
        test_abort_edges();
        test_restart();
        test_backpressure();
        test_random();

        wait_idle();
        if (err_count == 0)
            $display("tb_xmodem_block_sender passed");
        else
            $display("tb_xmodem_block_sender failed");
        $finish;
    end

endmodule
